// ----- hw/rtl/bitmap_slot_allocator_defines.svh -----
// assertion macros for the bitmap slot allocator
// included by modules that carry concurrent checks; no other dependencies
`ifndef BITMAP_SLOT_ALLOCATOR_DEFINES_SVH
`define BITMAP_SLOT_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS

// check sampled on the rising clock, disabled while reset is low
`define BSA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check sampled on the rising clock, active during reset too
`define BSA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define BSA_ASSERT(lbl, clk, rst_n, prop, msg)
`define BSA_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- hw/rtl/bsa_pkg.sv -----
// shared types, codes and helpers for the bitmap slot allocator
// no dependencies
package bsa_pkg;

  localparam int unsigned SlotsPerWord = 32;
  localparam int unsigned WordW        = 5;
  localparam int unsigned BitW         = 5;
  localparam int unsigned CfgW         = 6;
  localparam int unsigned MaxWords     = 32;
  localparam logic [CfgW-1:0] ActiveWordsRst = 6'd32;

  typedef enum logic [0:0] {
    OP_ACQUIRE = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_ACQUIRED    = 3'd0,
    ST_RELEASED    = 3'd1,
    ST_FULL        = 3'd2,
    ST_BAD_WORD    = 3'd3,
    ST_DOUBLE_FREE = 3'd4
  } status_e;

  typedef logic [SlotsPerWord-1:0] bitmap_t;

  // one read port and one write port of the bitmap store
  typedef struct packed {
    logic             rd_en;
    logic [WordW-1:0] rd_addr;
    logic             wr_en;
    logic [WordW-1:0] wr_addr;
    bitmap_t          wr_data;
  } store_req_t;

  // update of one entry of the full summary
  typedef struct packed {
    logic             en;
    logic [WordW-1:0] addr;
    logic             full;
  } sum_upd_t;

  // lowest clear bit of a word, 0 if none
  function automatic logic [BitW-1:0] lowest_zero(bitmap_t w);
    logic [BitW-1:0] res;
    res = '0;
    for (int i = SlotsPerWord - 1; i >= 0; i--) begin
      if (!w[i]) begin
        res = BitW'(i);
      end
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/bsa_if.sv -----
// request and response channel interfaces of the bitmap slot allocator
// depends on bsa_pkg
interface bsa_req_if import bsa_pkg::*; ();
  logic            valid;
  logic            ready;
  op_e             opcode;
  logic [WordW-1:0] word_index;
  logic [BitW-1:0]  bit_index;

  modport source (output valid, opcode, word_index, bit_index, input ready);
  modport sink   (input valid, opcode, word_index, bit_index, output ready);
endinterface

interface bsa_rsp_if import bsa_pkg::*; ();
  logic             valid;
  logic             ready;
  status_e          status;
  logic [WordW-1:0] slot_word;
  logic [BitW-1:0]  slot_bit;

  modport source (output valid, status, slot_word, slot_bit, input ready);
  modport sink   (input valid, status, slot_word, slot_bit, output ready);
endinterface

// ----- hw/rtl/bitmap_slot_allocator.sv -----
// First-fit slot allocator over a bitmap of 32-slot words. An acquire or a release that
// touches the bitmap goes through the store: the transaction is taken and the word is read from the
// store, then the word is modified and written back while the response is registered; the
// word is picked at once from a per-word full summary. An acquire with no free slot and a
// release of a word outside the active range are answered in the cycle after the transaction.
// One request is in flight at a time; the next request is taken while a response still waits
// as long as the response register frees at that edge. After reset every slot is free at
// once (no clearing pass). Write active_words only while no request is in flight.
// depends on bsa_pkg, bsa_if, bsa_store, bsa_summary and bitmap_slot_allocator_defines.svh
`include "bitmap_slot_allocator_defines.svh"

module bitmap_slot_allocator import bsa_pkg::*; #(
  parameter int unsigned NUM_WORDS = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            active_words_we_i,
  input  logic [CfgW-1:0] active_words_i,
  bsa_req_if.sink         req_i,
  bsa_rsp_if.source       rsp_o
);

  localparam int unsigned Depth = (NUM_WORDS > MaxWords) ? MaxWords : NUM_WORDS;

  typedef enum logic {
    S_IDLE,
    S_RMW
  } state_e;

  state_e           state_q;
  op_e              op_q;
  logic [WordW-1:0] addr_q;
  logic [BitW-1:0]  bit_q;
  logic [CfgW-1:0]  active_words_q;

  logic             out_valid_q;
  logic             out_valid_d;
  status_e          out_status_q;
  logic [WordW-1:0] out_word_q;
  logic [BitW-1:0]  out_bit_q;

  logic [CfgW-1:0]  n_eff;
  logic             accept;
  logic             is_acq;
  logic             bad_word;
  logic             found;
  logic [WordW-1:0] first_word;
  bitmap_t          rd_word;
  logic [BitW-1:0]  pick_bit;
  bitmap_t          new_word;
  logic             slot_used;
  store_req_t       store_req;
  sum_upd_t         sum_upd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_words_q <= ActiveWordsRst;
    end else if (active_words_we_i) begin
      active_words_q <= active_words_i;
    end
  end

  assign n_eff = (active_words_q > CfgW'(Depth)) ? CfgW'(Depth) : active_words_q;

  assign req_i.ready = (state_q == S_IDLE) && (!out_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;
  assign is_acq      = (req_i.opcode == OP_ACQUIRE);
  assign bad_word    = ({1'b0, req_i.word_index} >= n_eff);

  bsa_summary #(
    .Depth(Depth)
  ) u_summary (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .n_eff_i(n_eff),
    .upd_i  (sum_upd),
    .found_o(found),
    .first_o(first_word)
  );

  bsa_store #(
    .Depth(Depth)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (store_req),
    .rd_data_o(rd_word)
  );

  assign pick_bit  = lowest_zero(rd_word);
  assign slot_used = rd_word[bit_q];

  always_comb begin
    new_word = rd_word;
    unique case (op_q)
      OP_ACQUIRE: new_word[pick_bit] = 1'b1;
      OP_RELEASE: new_word[bit_q]    = 1'b0;
      default:    new_word = rd_word;
    endcase
  end

  always_comb begin
    store_req         = '0;
    store_req.rd_en   = accept && (is_acq ? found : !bad_word);
    store_req.rd_addr = is_acq ? first_word : req_i.word_index;
    store_req.wr_en   = (state_q == S_RMW) && ((op_q == OP_ACQUIRE) || slot_used);
    store_req.wr_addr = addr_q;
    store_req.wr_data = new_word;
  end

  assign sum_upd.en   = store_req.wr_en;
  assign sum_upd.addr = addr_q;
  assign sum_upd.full = &new_word;

  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp_o.valid && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == S_RMW) || (accept && !store_req.rd_en)) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= OP_ACQUIRE;
      addr_q       <= '0;
      bit_q        <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_ACQUIRED;
      out_word_q   <= '0;
      out_bit_q    <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (store_req.rd_en) begin
              state_q <= S_RMW;
              op_q    <= req_i.opcode;
              addr_q  <= store_req.rd_addr;
              bit_q   <= req_i.bit_index;
            end else begin
              out_status_q <= is_acq ? ST_FULL : ST_BAD_WORD;
              out_word_q   <= '0;
              out_bit_q    <= '0;
            end
          end
        end
        S_RMW: begin
          state_q <= S_IDLE;
          if (op_q == OP_ACQUIRE) begin
            out_status_q <= ST_ACQUIRED;
            out_word_q   <= addr_q;
            out_bit_q    <= pick_bit;
          end else begin
            out_status_q <= slot_used ? ST_RELEASED : ST_DOUBLE_FREE;
            out_word_q   <= '0;
            out_bit_q    <= '0;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.status    = out_status_q;
  assign rsp_o.slot_word = out_word_q;
  assign rsp_o.slot_bit  = out_bit_q;

  `BSA_ASSERT(a_rmw_one_cycle, clk_i, rst_ni, (state_q == S_RMW) |=> (state_q == S_IDLE), "rmw long")
  `BSA_ASSERT(a_rmw_out_free, clk_i, rst_ni, (state_q == S_RMW) |-> !out_valid_q, "rsp busy in rmw")
  `BSA_ASSERT_ALWAYS(a_wr_in_rmw, clk_i, store_req.wr_en |-> (state_q == S_RMW), "stray write")
  `BSA_ASSERT(a_acq_not_full, clk_i, rst_ni, (op_q == OP_ACQUIRE) && (state_q == S_RMW) |-> !(&rd_word), "full pick")

endmodule

// ----- hw/rtl/bsa_store.sv -----
// bitmap word store: synchronous memory with registered read and per-entry valid bits
// depends on bsa_pkg; an entry never written reads as all zeros
module bsa_store import bsa_pkg::*; #(
  parameter int unsigned Depth = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  store_req_t req_i,
  output bitmap_t    rd_data_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  bitmap_t          mem [Depth];
  logic [Depth-1:0] valid_q;
  bitmap_t          rd_data_q;
  logic             rd_vld_q;

  logic [AddrW-1:0] rd_a;
  logic [AddrW-1:0] wr_a;

  assign rd_a = req_i.rd_addr[AddrW-1:0];
  assign wr_a = req_i.wr_addr[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[wr_a] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[rd_a];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        valid_q[wr_a] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= valid_q[rd_a];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

// ----- hw/rtl/bsa_summary.sv -----
// per-word full summary and first-non-full word search
// depends on bsa_pkg
module bsa_summary import bsa_pkg::*; #(
  parameter int unsigned Depth = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CfgW-1:0]  n_eff_i,
  input  sum_upd_t         upd_i,
  output logic             found_o,
  output logic [WordW-1:0] first_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Depth-1:0] full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= '0;
    end else if (upd_i.en) begin
      full_q[upd_i.addr[AddrW-1:0]] <= upd_i.full;
    end
  end

  always_comb begin
    found_o = 1'b0;
    first_o = '0;
    for (int i = Depth - 1; i >= 0; i--) begin
      if (!full_q[i] && (CfgW'(i) < n_eff_i)) begin
        found_o = 1'b1;
        first_o = WordW'(i);
      end
    end
  end

endmodule

// ----- bench/slot_alloc_checker.sv -----
`timescale 1ns / 100ps
// checker for the bitmap slot allocator: watches both channels and the register port,
// predicts each response and compares it field by field; depends on bsa_pkg and bsa_if
module slot_alloc_checker import bsa_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            active_words_we_i,
  input  logic [CfgW-1:0] active_words_i,
  bsa_req_if              req_i,
  bsa_rsp_if              rsp_i,
  output int              errors_o,
  output int              pending_o
);

  typedef struct packed {
    status_e          status;
    logic [WordW-1:0] slot_word;
    logic [BitW-1:0]  slot_bit;
  } slot_result_t;

  bitmap_t         used_map [MaxWords];
  logic [CfgW-1:0] active_cfg;
  slot_result_t    expected_results [$];
  int              status_count [5];

  function automatic slot_result_t allocate_or_free(op_e op, logic [WordW-1:0] w,
                                                    logic [BitW-1:0] b);
    slot_result_t r;
    int unsigned  n;
    bit           found;
    r.status    = ST_FULL;
    r.slot_word = '0;
    r.slot_bit  = '0;
    found       = 1'b0;
    n = (active_cfg > MaxWords) ? MaxWords : int'(active_cfg);
    if (op == OP_ACQUIRE) begin
      for (int i = 0; i < int'(n); i++) begin
        if (!found && used_map[i] != '1) begin
          found = 1'b1;
          r.status = ST_ACQUIRED;
          r.slot_word = WordW'(i);
          for (int k = SlotsPerWord - 1; k >= 0; k--) begin
            if (!used_map[i][k]) begin
              r.slot_bit = BitW'(k);
            end
          end
          used_map[i][r.slot_bit] = 1'b1;
        end
      end
    end else if (int'(w) >= int'(n)) begin
      r.status = ST_BAD_WORD;
    end else if (!used_map[w][b]) begin
      r.status = ST_DOUBLE_FREE;
    end else begin
      used_map[w][b] = 1'b0;
      r.status = ST_RELEASED;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    slot_result_t exp;
    if (!rst_ni) begin
      for (int i = 0; i < MaxWords; i++) begin
        used_map[i] = '0;
      end
      for (int s = 0; s < 5; s++) begin
        status_count[s] = 0;
      end
      active_cfg = ActiveWordsRst;
      expected_results.delete();
      errors_o = 0;
      pending_o <= 0;
    end else begin
      if (active_words_we_i) begin
        active_cfg = active_words_i;
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_results.size() == 0) begin
          $error("response transaction with no request outstanding: status %0d",
                 rsp_i.status);
          errors_o = errors_o + 1;
        end else begin
          exp = expected_results.pop_front();
          status_count[int'(exp.status)]++;
          if (rsp_i.status !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, rsp_i.status);
            errors_o = errors_o + 1;
          end
          if (rsp_i.slot_word !== exp.slot_word) begin
            $error("slot_word: expected %0d, got %0d", exp.slot_word, rsp_i.slot_word);
            errors_o = errors_o + 1;
          end
          if (rsp_i.slot_bit !== exp.slot_bit) begin
            $error("slot_bit: expected %0d, got %0d", exp.slot_bit, rsp_i.slot_bit);
            errors_o = errors_o + 1;
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        expected_results.push_back(allocate_or_free(req_i.opcode, req_i.word_index,
                                                    req_i.bit_index));
      end
      pending_o <= expected_results.size();
    end
  end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// top of the bitmap slot allocator bench: clock, reset, request and response traffic,
// register writes and the verdict; depends on bsa_pkg, bsa_if and slot_alloc_checker
module testbench;
  import bsa_pkg::*;

  localparam int CycleLimit = 300000;
  localparam int LongHold   = 80;

  logic            clk_i;
  logic            rst_ni;
  logic            active_words_we;
  logic [CfgW-1:0] active_words;
  int              errors;
  int              pending;
  int              cycle_count = 0;
  int unsigned     req_gap_max = 12;
  int unsigned     rsp_gap_max = 12;
  bit              long_hold = 1'b0;
  int              cfg_writes = 0;
  logic [9:0]      live_slots [$];

  bsa_req_if req_ch ();
  bsa_rsp_if rsp_ch ();

  bitmap_slot_allocator #(
    .NUM_WORDS(32)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .active_words_we_i(active_words_we),
    .active_words_i   (active_words),
    .req_i            (req_ch),
    .rsp_o            (rsp_ch)
  );

  slot_alloc_checker i_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .active_words_we_i(active_words_we),
    .active_words_i   (active_words),
    .req_i            (req_ch),
    .rsp_i            (rsp_ch),
    .errors_o         (errors),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycle_count, pending);
      $display("Verification failed");
      $finish;
    end
  end

  // slots handed out by the block become release targets
  always @(posedge clk_i) begin
    if (rsp_ch.valid && rsp_ch.ready && rsp_ch.status === ST_ACQUIRED) begin
      live_slots.push_back({rsp_ch.slot_word, rsp_ch.slot_bit});
    end
  end

  initial begin
    int unsigned gap;
    rsp_ch.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = $urandom_range(0, rsp_gap_max);
      if (long_hold) begin
        long_hold = 1'b0;
        gap = gap + LongHold;
      end
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_ch.valid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  task automatic send_item(input op_e op, input logic [WordW-1:0] w,
                           input logic [BitW-1:0] b);
    int unsigned gap;
    int          hit;
    gap = $urandom_range(0, req_gap_max);
    if (op == OP_RELEASE) begin
      hit = -1;
      for (int i = 0; i < live_slots.size(); i++) begin
        if (hit < 0 && live_slots[i] == {w, b}) begin
          hit = i;
        end
      end
      if (hit >= 0) begin
        live_slots.delete(hit);
      end
    end
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_ch.valid      <= 1'b1;
    req_ch.opcode     <= op;
    req_ch.word_index <= w;
    req_ch.bit_index  <= b;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_active_words(input logic [CfgW-1:0] value);
    wait_idle();
    active_words_we <= 1'b1;
    active_words    <= value;
    @(negedge clk_i);
    active_words_we <= 1'b0;
    cfg_writes++;
  endtask

  initial begin
    logic [CfgW-1:0] phase_words [8];
    int unsigned     phase_items;
    int unsigned     acq_pct;
    int unsigned     idx;
    logic [9:0]      slot;
    phase_words = '{6'd1, 6'd3, 6'd0, 6'd63, 6'd2, 6'd32, 6'd0, 6'd1};
    phase_words[6] = CfgW'($urandom_range(1, 32));
    rst_ni            = 1'b0;
    active_words_we   = 1'b0;
    active_words      = ActiveWordsRst;
    req_ch.valid      = 1'b0;
    req_ch.opcode     = OP_ACQUIRE;
    req_ch.word_index = '0;
    req_ch.bit_index  = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset width, reuse of a freed slot, double free
    send_item(OP_ACQUIRE, 5'd31, 5'd31);
    send_item(OP_ACQUIRE, 5'd0, 5'd0);
    send_item(OP_ACQUIRE, 5'd17, 5'd9);
    send_item(OP_RELEASE, 5'd0, 5'd1);
    send_item(OP_RELEASE, 5'd0, 5'd1);
    send_item(OP_ACQUIRE, 5'd0, 5'd0);
    send_item(OP_RELEASE, 5'd31, 5'd31);
    send_item(OP_RELEASE, 5'd0, 5'd0);
    // one word: anything above word 0 is out of range
    write_active_words(6'd1);
    send_item(OP_RELEASE, 5'd1, 5'd0);
    send_item(OP_RELEASE, 5'd31, 5'd0);
    send_item(OP_ACQUIRE, 5'd0, 5'd0);
    // no words at all
    write_active_words(6'd0);
    send_item(OP_ACQUIRE, 5'd0, 5'd0);
    send_item(OP_RELEASE, 5'd0, 5'd0);
    // count above the word limit clamps to 32
    write_active_words(6'd63);
    send_item(OP_RELEASE, 5'd31, 5'd31);
    send_item(OP_ACQUIRE, 5'd21, 5'd10);
    send_item(OP_RELEASE, 5'd0, 5'd3);

    for (int p = 0; p < 8; p++) begin
      write_active_words(phase_words[p]);
      req_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 12;
      rsp_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 12;
      phase_items = (phase_words[p] == 0) ? 20 : 52;
      acq_pct = (phase_words[p] <= 3) ? 75 : $urandom_range(45, 80);
      if (p == 3) begin
        long_hold = 1'b1;
      end
      for (int k = 0; k < int'(phase_items); k++) begin
        if ($urandom_range(0, 99) < acq_pct) begin
          send_item(OP_ACQUIRE, WordW'($urandom_range(0, 31)), BitW'($urandom_range(0, 31)));
        end else if (live_slots.size() > 0 && $urandom_range(0, 99) < 85) begin
          idx = $urandom_range(0, live_slots.size() - 1);
          slot = live_slots[idx];
          send_item(OP_RELEASE, slot[9:5], slot[4:0]);
        end else begin
          send_item(OP_RELEASE, WordW'($urandom_range(0, 31)), BitW'($urandom_range(0, 31)));
        end
      end
    end

    wait_idle();
    repeat (10) @(negedge clk_i);
    $display("checked %0d acquired, %0d released, %0d full, %0d out of range, %0d double free",
             i_check.status_count[ST_ACQUIRED], i_check.status_count[ST_RELEASED],
             i_check.status_count[ST_FULL], i_check.status_count[ST_BAD_WORD],
             i_check.status_count[ST_DOUBLE_FREE]);
    $display("across %0d active word settings, with a long response back-pressure stretch",
             cfg_writes);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
